// ===== src/emfp_pkg.sv =====
// Shared types and constants for the energy meter frame parser.
// No dependencies; used by the front, queue, back and top-level files.
package emfp_pkg;

  // Frame layout
  localparam int unsigned FrameLen  = 24;
  localparam int unsigned DataBytes = 21;  // bytes 2..22, covered by the checksum
  localparam int unsigned PosW      = 5;

  localparam logic [PosW-1:0] FirstDataPos = 5'd2;
  localparam logic [PosW-1:0] LastPos      = 5'd23;

  // Header bytes
  localparam logic [7:0] StateNormal   = 8'h55;
  localparam logic [7:0] StateUnusable = 8'hAA;
  localparam logic [3:0] StateFaultHi  = 4'hF;
  localparam logic [7:0] CheckByte     = 8'h5A;

  // Item classes passed from front to back
  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_LAST   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;  // state byte for a header, frame byte otherwise
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNUSABLE = 2'd1,
    STATUS_AC_FAULT = 2'd2,
    STATUS_CHECKSUM = 2'd3
  } frame_status_e;

  typedef struct packed {
    frame_status_e status;
    logic [7:0]    state_byte;
    logic [23:0]   voltage_param;
    logic [23:0]   voltage_reg;
    logic [23:0]   current_param;
    logic [23:0]   current_reg;
    logic [23:0]   power_param;
    logic [23:0]   power_reg;
    logic [7:0]    update_flags;
    logic [15:0]   pf_count;
  } result_t;

  function automatic logic is_state_byte(input logic [7:0] b);
    return (b == StateNormal) || (b == StateUnusable) || (b[7:4] == StateFaultHi);
  endfunction

endpackage

// ===== src/emfp_front.sv =====
// Front end: accepts received bytes, hunts for the frame header and tags
// frame bytes for the back end. Depends on emfp_pkg.
module emfp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output emfp_pkg::cmd_t cmd_o
);

  logic                      accept;
  logic [7:0]                prev_q, prev_d;
  logic                      in_frame_q, in_frame_d;
  logic [emfp_pkg::PosW-1:0] pos_q, pos_d;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Header search and position tracking
  always_comb begin
    prev_d     = prev_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    push_o     = 1'b0;
    cmd_o.kind = emfp_pkg::CMD_DATA;
    cmd_o.data = rx_byte_i;
    if (accept) begin
      prev_d = rx_byte_i;
      if (!in_frame_q) begin
        if (rx_byte_i == emfp_pkg::CheckByte && emfp_pkg::is_state_byte(prev_q)) begin
          push_o     = 1'b1;
          cmd_o.kind = emfp_pkg::CMD_HEADER;
          cmd_o.data = prev_q;
          in_frame_d = 1'b1;
          pos_d      = emfp_pkg::FirstDataPos;
        end
      end else if (pos_q < emfp_pkg::FirstDataPos || pos_q > emfp_pkg::LastPos) begin
        // bad count: drop out of the frame
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else if (pos_q == emfp_pkg::LastPos) begin
        push_o     = 1'b1;
        cmd_o.kind = emfp_pkg::CMD_LAST;
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else begin
        push_o = 1'b1;
        pos_d  = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
    end else begin
      prev_q     <= prev_d;
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
    end
  end

endmodule

// ===== src/emfp_queue.sv =====
// Short FIFO of tagged items between front and back end.
// Depends on emfp_pkg for the item type.
module emfp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  emfp_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output emfp_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  emfp_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/emfp_back.sv =====
// Back end: collects frame bytes in a shift line, keeps the checksum and
// loads the result register at the checksum byte. Depends on emfp_pkg.
module emfp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  emfp_pkg::cmd_t   cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output emfp_pkg::result_t result_o
);

  logic [7:0]        data_q [emfp_pkg::DataBytes];
  logic [7:0]        state_q;
  logic [7:0]        sum_q;
  logic              out_valid_q, out_valid_d;
  emfp_pkg::result_t res_q;
  emfp_pkg::frame_status_e status;
  logic              slot_free;
  logic              is_last;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign is_last     = (cmd_i.kind == emfp_pkg::CMD_LAST);
  // Only the checksum byte needs room in the output register
  assign pop_o       = cmd_valid_i && (!is_last || slot_free);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // Status, state byte takes precedence over checksum
  always_comb begin
    if (state_q == emfp_pkg::StateUnusable) begin
      status = emfp_pkg::STATUS_UNUSABLE;
    end else if (state_q[7:4] == emfp_pkg::StateFaultHi) begin
      status = emfp_pkg::STATUS_AC_FAULT;
    end else if (sum_q != cmd_i.data) begin
      status = emfp_pkg::STATUS_CHECKSUM;
    end else begin
      status = emfp_pkg::STATUS_OK;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && is_last) begin
      out_valid_d = 1'b1;
    end
  end

  // Frame bytes and checksum
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      case (cmd_i.kind)
        emfp_pkg::CMD_HEADER: begin
          state_q <= cmd_i.data;
          sum_q   <= '0;
        end
        emfp_pkg::CMD_DATA: begin
          sum_q <= sum_q + cmd_i.data;
          for (int i = 0; i < emfp_pkg::DataBytes - 1; i++) begin
            data_q[i] <= data_q[i+1];
          end
          data_q[emfp_pkg::DataBytes-1] <= cmd_i.data;
        end
        emfp_pkg::CMD_LAST: begin
          res_q.status        <= status;
          res_q.state_byte    <= state_q;
          res_q.voltage_param <= {data_q[0], data_q[1], data_q[2]};
          res_q.voltage_reg   <= {data_q[3], data_q[4], data_q[5]};
          res_q.current_param <= {data_q[6], data_q[7], data_q[8]};
          res_q.current_reg   <= {data_q[9], data_q[10], data_q[11]};
          res_q.power_param   <= {data_q[12], data_q[13], data_q[14]};
          res_q.power_reg     <= {data_q[15], data_q[16], data_q[17]};
          res_q.update_flags  <= data_q[18];
          res_q.pf_count      <= {data_q[19], data_q[20]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/energy_meter_frame_parser.sv =====
// Energy meter frame parser, top level.
// Throughput: one received byte per cycle; the queue between front and back
// end lets bytes keep coming while a result waits in the output register, until it fills.
// Result path: the checksum byte is written into the queue at the accepting edge and then
// loaded into the output register; held back while an earlier result is stalled.
// Reset: asynchronous active low; clears header search, queue and output valid.
module energy_meter_frame_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  state_byte_o,
  output logic [23:0] voltage_param_o,
  output logic [23:0] voltage_reg_o,
  output logic [23:0] current_param_o,
  output logic [23:0] current_reg_o,
  output logic [23:0] power_param_o,
  output logic [23:0] power_reg_o,
  output logic [7:0]  update_flags_o,
  output logic [15:0] pf_count_o
);

  logic              push, q_full, q_valid, pop;
  emfp_pkg::cmd_t    push_cmd, pop_cmd;
  emfp_pkg::result_t result;

  emfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  emfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (pop_cmd)
  );

  emfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  // Break the result record out onto the ports
  assign frame_status_o  = result.status;
  assign state_byte_o    = result.state_byte;
  assign voltage_param_o = result.voltage_param;
  assign voltage_reg_o   = result.voltage_reg;
  assign current_param_o = result.current_param;
  assign current_reg_o   = result.current_reg;
  assign power_param_o   = result.power_param;
  assign power_reg_o     = result.power_reg;
  assign update_flags_o  = result.update_flags;
  assign pf_count_o      = result.pf_count;

endmodule
